// ===== rtl/tcaof_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcaof_pkg;

  // Width of the shared arrival sequence number.
  localparam int unsigned SEQ_W = 16;
  // Width of the identifier field on the ports.
  localparam int unsigned FIELD_ID_W = 16;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;
  localparam int unsigned DEF_ID_BITS     = 16;

  typedef enum logic [1:0] {
    CMD_ENQ     = 2'd0,
    CMD_DEQ_ANY = 2'd1,
    CMD_DEQ_CAT = 2'd2,
    CMD_DEQ_DOG = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_CAT  = 2'd1,
    CLS_DOG  = 2'd2
  } cls_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                  cmd;
    logic [1:0]            item_class;
    logic [FIELD_ID_W-1:0] item_id;
  } in_item_t;

  typedef struct packed {
    status_e               status;
    cls_e                  out_class;
    logic [FIELD_ID_W-1:0] out_id;
    logic                  all_empty;
  } out_item_t;

  // Requests from the command decode to one class queue.
  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

  // What a class queue reports about its current head and fill.
  typedef struct packed {
    logic             empty;
    logic             full;
    logic [SEQ_W-1:0] head_seq;
  } ring_stat_t;

endpackage

`default_nettype wire

// ===== rtl/tcaof_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcaof_ring #(
  parameter int unsigned QUEUE_DEPTH = tcaof_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned ID_BITS     = tcaof_pkg::DEF_ID_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcaof_pkg::ring_ctrl_t       ctrl_i,
  input  logic [ID_BITS-1:0]          push_id_i,
  input  logic [tcaof_pkg::SEQ_W-1:0] push_seq_i,
  output tcaof_pkg::ring_stat_t       stat_o,
  output logic [ID_BITS-1:0]          head_id_o,
  output logic                        empty_next_o
);
  import tcaof_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENT_W = ID_BITS + SEQ_W;

  logic [ENT_W-1:0] mem_q [QUEUE_DEPTH];
  logic [ENT_W-1:0] rd_q;
  logic [ENT_W-1:0] wr_data;

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign wr_data = {push_id_i, push_seq_i};

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (ctrl_i.push) begin
      tail_d = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
      cnt_d  = cnt_q + 1'b1;
    end else if (ctrl_i.pop) begin
      head_d = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
      cnt_d  = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // The read port always fetches the entry at the next head, so the head is
  // ready in a register. A push into the slot being fetched is forwarded.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[tail_q] <= wr_data;
    end
    if (ctrl_i.push && (tail_q == head_d)) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= mem_q[head_d];
    end
  end

  assign stat_o.empty    = (cnt_q == '0);
  assign stat_o.full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign stat_o.head_seq = rd_q[SEQ_W-1:0];
  assign head_id_o       = rd_q[ENT_W-1:SEQ_W];
  assign empty_next_o    = (cnt_d == '0);

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !ctrl_i.push)
    else $error("push into a full queue");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.empty |-> !ctrl_i.pop)
    else $error("pop from an empty queue");

  a_fill_tracks_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.push && !ctrl_i.pop |=> (cnt_q == $past(cnt_q) + 1'b1) && $stable(head_q))
    else $error("fill count and pointers disagree after a push");

endmodule

`default_nettype wire

// ===== rtl/tcaof_oreg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcaof_oreg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  tcaof_pkg::out_item_t data_i,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tcaof_pkg::out_item_t out_data_o
);
  import tcaof_pkg::*;

  logic      valid_q, valid_d;
  out_item_t data_q;

  // The register can take a new result when it is empty or being drained.
  assign busy_o = valid_q && out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ===== rtl/two_class_age_ordered_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-class age-ordered FIFO. Items of class cat or dog are queued in one
// ring per class, each entry tagged with a 16-bit arrival number taken from
// a shared counter that advances on every successful enqueue. A command can
// enqueue an item, take the oldest item of either class, or take the head of
// one class; every command returns exactly one result with a status, the
// dequeued class and id, and a flag that is set when both queues are empty
// afterwards. The oldest head is chosen by the sign of the wrapped difference
// of the two arrival numbers, so ordering stays correct across counter wrap
// as long as the two heads are fewer than 32768 arrivals apart. The command
// decode works on the head entries, which each ring keeps prefetched in a
// register fed by its memory read port, and the result lands in an output
// register in the cycle after the transfer in. A new command can be taken
// in every cycle; the input is stalled only while a result is held in the
// output register and the output side is stalled. There is no clearing pass
// after reset and the queue memories need none.
module two_class_age_ordered_fifo #(
  parameter int unsigned QUEUE_DEPTH = tcaof_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned ID_BITS     = tcaof_pkg::DEF_ID_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tcaof_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tcaof_pkg::out_item_t out_data_o
);
  import tcaof_pkg::*;

  logic               in_fire;
  logic               oreg_busy;
  logic [SEQ_W-1:0]   seq_q, seq_d;
  logic [ID_BITS-1:0] push_id;
  logic [SEQ_W-1:0]   seq_diff;
  logic               cat_older;

  ring_ctrl_t         cat_ctrl, dog_ctrl;
  ring_stat_t         cat_st, dog_st;
  logic [ID_BITS-1:0] cat_head_id, dog_head_id;
  logic               cat_empty_next, dog_empty_next;

  out_item_t          res;

  // A transfer in happens whenever a command is valid and the output register
  // has room for its result, which includes the cycle in which the old result leaves.
  assign in_stall_o = oreg_busy;
  assign in_fire    = in_valid_i && !oreg_busy;

  // Ids are stored at the configured width.
  assign push_id = ID_BITS'(in_data_i.item_id);

  // The cat head is older when the wrapped difference is negative; on a tie
  // the dog head wins.
  assign seq_diff  = cat_st.head_seq - dog_st.head_seq;
  assign cat_older = seq_diff[SEQ_W-1];

  always_comb begin
    cat_ctrl      = '0;
    dog_ctrl      = '0;
    res.status    = ST_OK;
    res.out_class = CLS_NONE;
    res.out_id    = '0;

    unique case (in_data_i.cmd)
      CMD_ENQ: begin
        if (in_data_i.item_class == CLS_CAT) begin
          if (cat_st.full) begin
            res.status = ST_FULL;
          end else begin
            cat_ctrl.push = in_fire;
          end
        end else if (in_data_i.item_class == CLS_DOG) begin
          if (dog_st.full) begin
            res.status = ST_FULL;
          end else begin
            dog_ctrl.push = in_fire;
          end
        end else begin
          res.status = ST_UNKNOWN;
        end
      end
      CMD_DEQ_ANY: begin
        if (cat_st.empty && dog_st.empty) begin
          res.status = ST_EMPTY;
        end else if (cat_st.empty || (!dog_st.empty && !cat_older)) begin
          dog_ctrl.pop = in_fire;
        end else begin
          cat_ctrl.pop = in_fire;
        end
      end
      CMD_DEQ_CAT: begin
        if (cat_st.empty) begin
          res.status = ST_EMPTY;
        end else begin
          cat_ctrl.pop = in_fire;
        end
      end
      CMD_DEQ_DOG: begin
        if (dog_st.empty) begin
          res.status = ST_EMPTY;
        end else begin
          dog_ctrl.pop = in_fire;
        end
      end
      default: begin
        res.status = ST_EMPTY;
      end
    endcase

    // The class and id of the popped head; zero when nothing is popped.
    if (cat_ctrl.pop) begin
      res.out_class = CLS_CAT;
      res.out_id    = FIELD_ID_W'(cat_head_id);
    end else if (dog_ctrl.pop) begin
      res.out_class = CLS_DOG;
      res.out_id    = FIELD_ID_W'(dog_head_id);
    end

    res.all_empty = cat_empty_next && dog_empty_next;
  end

  // The arrival counter advances only when an item is actually stored.
  always_comb begin
    seq_d = seq_q;
    if (cat_ctrl.push || dog_ctrl.push) begin
      seq_d = seq_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
    end else begin
      seq_q <= seq_d;
    end
  end

  tcaof_ring #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_cat_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (cat_ctrl),
    .push_id_i    (push_id),
    .push_seq_i   (seq_q),
    .stat_o       (cat_st),
    .head_id_o    (cat_head_id),
    .empty_next_o (cat_empty_next)
  );

  tcaof_ring #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dog_ring (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (dog_ctrl),
    .push_id_i    (push_id),
    .push_seq_i   (seq_q),
    .stat_o       (dog_st),
    .head_id_o    (dog_head_id),
    .empty_next_o (dog_empty_next)
  );

  tcaof_oreg u_oreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire),
    .data_i      (res),
    .busy_o      (oreg_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_one_queue_op : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cat_ctrl.push, cat_ctrl.pop, dog_ctrl.push, dog_ctrl.pop}) <= 1)
    else $error("more than one queue operation in a cycle");

  a_ops_need_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cat_ctrl.push || cat_ctrl.pop || dog_ctrl.push || dog_ctrl.pop) |-> in_fire)
    else $error("queue operation without an input transfer");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted command gave no result");

  a_seq_on_push_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cat_ctrl.push || dog_ctrl.push) |=> $stable(seq_q))
    else $error("arrival counter moved without a push");

endmodule

`default_nettype wire
